[sv/lobm_pkg.sv]
// Shared types, codes and sizes of the order book matcher.
package lobm_pkg;

	localparam int PRICE_LEVELS  = 1024;
	localparam int MAX_ORDERS    = 1024;
	localparam int FRACTION_BITS = 16;

	localparam int TICK_W  = $clog2(PRICE_LEVELS);
	localparam int ID_W    = $clog2(MAX_ORDERS);
	localparam int LVL_W   = TICK_W + 1;
	localparam int LVL_NUM = 2 * PRICE_LEVELS;
	localparam int QTY_W   = 32;
	localparam int COST_W  = QTY_W + TICK_W;
	localparam int DIV_W   = COST_W + FRACTION_BITS;
	localparam int AVG_W   = 26;

	localparam logic [1:0] REQ_LIMIT  = 2'd0;
	localparam logic [1:0] REQ_MARKET = 2'd1;
	localparam logic [1:0] REQ_CANCEL = 2'd2;
	localparam logic [1:0] REQ_OTHER  = 2'd3;

	localparam logic [1:0] SIDE_BUY     = 2'd0;
	localparam logic [1:0] SIDE_SELL    = 2'd1;
	localparam logic [1:0] SIDE_NONE    = 2'd2;
	localparam logic [1:0] SIDE_NONE_HI = 2'd3;

	localparam logic [1:0] FILL_NONE = 2'd0;
	localparam logic [1:0] FILL_BUY  = 2'd1;
	localparam logic [1:0] FILL_SELL = 2'd2;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [1:0]       side;
		logic [9:0]       order_id;
		logic [9:0]       limit_price;
		logic [QTY_W-1:0] order_quantity;
	} lobm_req_t;

	typedef struct packed {
		logic [AVG_W-1:0] avg_price;
		logic [QTY_W-1:0] fill_quantity;
		logic [1:0]       fill_side;
	} lobm_res_t;

	typedef struct packed {
		logic known;
		logic inactive;
	} lobm_status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CAN_RD,
		ST_CAN_WR,
		ST_SCAN,
		ST_LVL,
		ST_ENT,
		ST_ACC,
		ST_FIN,
		ST_REST,
		ST_PUSH,
		ST_DIV_GO,
		ST_DIV,
		ST_DONE
	} lobm_state_t;

endpackage

[sv/lobm_ram.sv]
// Generic single write, single read RAM with registered read data.
module lobm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/lobm_div.sv]
// Restoring divider, one quotient bit per cycle, for the average fill price.
module lobm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lobm_pkg::DIV_W-1:0] dividend,
	input  logic [lobm_pkg::QTY_W-1:0] divisor,
	output logic                      done,
	output logic [lobm_pkg::DIV_W-1:0] quotient
);
	import lobm_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [QTY_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [QTY_W-1:0] dvs_q;
	logic [QTY_W:0]   rem_sh;
	logic             take;

	assign rem_sh = {rem_q[QTY_W-1:0], quo_q[DIV_W-1]};
	assign take   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= take ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/limit_order_book_matcher_unit.sv]
// Price-time priority order book matcher: sequencer over the book memories.
//
//  channel   | signals                 | handshake
//  ----------+-------------------------+---------------------------------
//  request   | req (lobm_req_t)        | word taken when start && !busy
//  result    | result (lobm_res_t)     | word valid for one cycle on done
//
// An order walks the opposite book price tick by price tick, takes resting
// entries and pops stale ones, rests the remainder of a limit order and,
// when anything fills, runs the average-price divider. A cancel reads and
// then writes the order status; a rejected word goes straight to done.
// The walk is bound by the single read port of each book memory.
// After reset a clearing pass over all 2048 level entries runs with busy high.
// The result is not held: done pulses once and the next word may follow.
module limit_order_book_matcher_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  lobm_pkg::lobm_req_t req,
	output logic                busy,
	output logic                done,
	output lobm_pkg::lobm_res_t result
);
	import lobm_pkg::*;

	lobm_state_t state_q, state_d;

	lobm_req_t        req_q;
	logic [QTY_W-1:0] want_q, filled_q;
	logic [COST_W-1:0] cost_q, prod_q;
	logic [TICK_W:0]  k_q;
	logic [ID_W-1:0]  h_q, t_q, nxt_q;
	logic             remzero_q;
	logic [LVL_W-1:0] clr_q;
	lobm_res_t        res_q;

	// memory ports
	logic st_we, rem_we, nxt_we, head_we, tail_we, occ_we;
	logic [ID_W-1:0]  st_wa, st_ra, rem_wa, rem_ra, nxt_wa, nxt_ra;
	logic [LVL_W-1:0] head_wa, head_ra, tail_wa, tail_ra, occ_wa, occ_ra;
	lobm_status_t     st_wd, st_rd;
	logic [QTY_W-1:0] rem_wd, rem_rd;
	logic [ID_W-1:0]  nxt_wd, nxt_rd, head_wd, head_rd, tail_wd, tail_rd;
	logic             occ_wd, occ_rd;

	lobm_ram #(.WIDTH($bits(lobm_status_t)), .DEPTH(MAX_ORDERS)) u_status (
		.clk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
	lobm_ram #(.WIDTH(QTY_W), .DEPTH(MAX_ORDERS)) u_remain (
		.clk, .we(rem_we), .waddr(rem_wa), .wdata(rem_wd), .raddr(rem_ra), .rdata(rem_rd));
	lobm_ram #(.WIDTH(ID_W), .DEPTH(MAX_ORDERS)) u_next (
		.clk, .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd));
	lobm_ram #(.WIDTH(ID_W), .DEPTH(LVL_NUM)) u_head (
		.clk, .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(head_ra),
		.rdata(head_rd));
	lobm_ram #(.WIDTH(ID_W), .DEPTH(LVL_NUM)) u_tail (
		.clk, .we(tail_we), .waddr(tail_wa), .wdata(tail_wd), .raddr(tail_ra),
		.rdata(tail_rd));
	lobm_ram #(.WIDTH(1), .DEPTH(LVL_NUM)) u_occ (
		.clk, .we(occ_we), .waddr(occ_wa), .wdata(occ_wd), .raddr(occ_ra), .rdata(occ_rd));

	// divider
	logic             div_start, div_done;
	logic [DIV_W-1:0] div_q;

	lobm_div u_div (
		.clk, .arst_n, .start(div_start),
		.dividend({cost_q, {FRACTION_BITS{1'b0}}}), .divisor(filled_q),
		.done(div_done), .quotient(div_q));

	// decode
	logic             accept, is_buy, is_limit, scan_stop;
	logic [TICK_W-1:0] p, lim;
	logic [ID_W-1:0]  id;
	logic [LVL_W-1:0] opp_lvl, own_lvl;
	logic [QTY_W-1:0] m;
	logic [AVG_W-1:0] avg_sat;

	assign accept   = start && !busy;
	assign is_buy   = req_q.side == SIDE_BUY;
	assign is_limit = req_q.req_type == REQ_LIMIT;
	assign id       = req_q.order_id[ID_W-1:0];
	assign lim      = req_q.limit_price[TICK_W-1:0];
	// buys walk asks upward, sells walk bids downward
	assign p        = is_buy ? k_q[TICK_W-1:0] : ~k_q[TICK_W-1:0];
	assign opp_lvl  = {~req_q.side[0], p};
	assign own_lvl  = {req_q.side[0], lim};
	assign scan_stop = (want_q == '0) || k_q[TICK_W] ||
		(is_limit && is_buy && (p > lim)) || (is_limit && !is_buy && (p < lim));
	assign m        = (want_q < rem_rd) ? want_q : rem_rd;
	assign avg_sat  = (|div_q[DIV_W-1:AVG_W]) ? '1 : div_q[AVG_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == LVL_W'(LVL_NUM - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (req.req_type == REQ_CANCEL) state_d = ST_CAN_RD;
					else if (req.req_type != REQ_LIMIT && req.req_type != REQ_MARKET)
						state_d = ST_DONE;
					else if (req.side != SIDE_BUY && req.side != SIDE_SELL)
						state_d = ST_DONE;
					else state_d = ST_SCAN;
				end
			end
			ST_CAN_RD: state_d = ST_CAN_WR;
			ST_CAN_WR: state_d = ST_DONE;
			ST_SCAN:   state_d = scan_stop ? ST_FIN : ST_LVL;
			ST_LVL:    state_d = occ_rd ? ST_ENT : ST_SCAN;
			ST_ENT: begin
				if (!st_rd.inactive) state_d = ST_ACC;
				else if (h_q == t_q) state_d = ST_SCAN;
			end
			ST_ACC: begin
				if (!remzero_q || want_q == '0) state_d = ST_FIN;
				else if (h_q == t_q) state_d = ST_SCAN;
				else state_d = ST_ENT;
			end
			ST_FIN:    state_d = is_limit ? ST_REST : ST_DIV_GO;
			ST_REST: begin
				if (want_q != '0 && !st_rd.known && !st_rd.inactive) state_d = ST_PUSH;
				else state_d = ST_DIV_GO;
			end
			ST_PUSH:   state_d = ST_DIV_GO;
			ST_DIV_GO: state_d = (filled_q == '0) ? ST_DONE : ST_DIV;
			ST_DIV:    if (div_done) state_d = ST_DONE;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory control and outputs
	always_comb begin
		st_we = 1'b0; st_wa = id; st_wd = '0; st_ra = id;
		rem_we = 1'b0; rem_wa = h_q; rem_wd = '0; rem_ra = h_q;
		nxt_we = 1'b0; nxt_wa = tail_rd; nxt_wd = id; nxt_ra = h_q;
		head_we = 1'b0; head_wa = opp_lvl; head_wd = nxt_q; head_ra = opp_lvl;
		tail_we = 1'b0; tail_wa = own_lvl; tail_wd = id; tail_ra = opp_lvl;
		occ_we = 1'b0; occ_wa = opp_lvl; occ_wd = 1'b0; occ_ra = opp_lvl;
		div_start = 1'b0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				st_we  = 1'b1;
				st_wa  = clr_q[ID_W-1:0];
				occ_we = 1'b1;
				occ_wa = clr_q;
			end
			ST_IDLE: busy = 1'b0;
			ST_CAN_WR: begin
				st_we = st_rd.known && !st_rd.inactive;
				st_wd = '{known: 1'b1, inactive: 1'b1};
			end
			ST_LVL: begin
				st_ra  = head_rd;
				rem_ra = head_rd;
				nxt_ra = head_rd;
			end
			ST_ENT: begin
				if (st_rd.inactive) begin
					if (h_q == t_q) begin
						occ_we = 1'b1;
					end else begin
						head_we = 1'b1;
						head_wd = nxt_rd;
						st_ra   = nxt_rd;
						rem_ra  = nxt_rd;
						nxt_ra  = nxt_rd;
					end
				end else begin
					rem_we = 1'b1;
					rem_wd = rem_rd - m;
					st_wa  = h_q;
					st_we  = (rem_rd == m);
					st_wd  = '{known: st_rd.known, inactive: 1'b1};
				end
			end
			ST_ACC: begin
				if (remzero_q) begin
					if (h_q == t_q) begin
						occ_we = 1'b1;
					end else begin
						head_we = 1'b1;
						st_ra   = nxt_q;
						rem_ra  = nxt_q;
						nxt_ra  = nxt_q;
					end
				end
			end
			ST_REST: begin
				occ_ra  = own_lvl;
				tail_ra = own_lvl;
				rem_wa  = id;
				rem_wd  = want_q;
				if (want_q == '0) begin
					st_we = 1'b1;
					st_wd = '{known: st_rd.known, inactive: 1'b1};
				end else if (!st_rd.known && !st_rd.inactive) begin
					st_we  = 1'b1;
					st_wd  = '{known: 1'b1, inactive: 1'b0};
					rem_we = 1'b1;
				end
			end
			ST_PUSH: begin
				tail_we = 1'b1;
				occ_wa  = own_lvl;
				head_wa = own_lvl;
				head_wd = id;
				if (!occ_rd) begin
					head_we = 1'b1;
					occ_we  = 1'b1;
					occ_wd  = 1'b1;
				end else begin
					nxt_we = 1'b1;
				end
			end
			ST_DIV_GO: div_start = filled_q != '0;
			ST_DONE:   done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q    <= req;
					want_q   <= req.order_quantity;
					filled_q <= '0;
					cost_q   <= '0;
					k_q      <= '0;
					res_q    <= '0;
				end
			end
			ST_LVL: begin
				h_q <= head_rd;
				t_q <= tail_rd;
				if (!occ_rd) k_q <= k_q + 1'b1;
			end
			ST_ENT: begin
				nxt_q <= nxt_rd;
				if (st_rd.inactive) begin
					if (h_q == t_q) k_q <= k_q + 1'b1;
					else h_q <= nxt_rd;
				end else begin
					want_q    <= want_q - m;
					filled_q  <= filled_q + m;
					prod_q    <= COST_W'(m * p);
					remzero_q <= rem_rd == m;
				end
			end
			ST_ACC: begin
				cost_q <= cost_q + prod_q;
				if (remzero_q) begin
					if (h_q == t_q) k_q <= k_q + 1'b1;
					else h_q <= nxt_q;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					res_q.avg_price     <= avg_sat;
					res_q.fill_quantity <= filled_q;
					res_q.fill_side     <= is_buy ? FILL_BUY : FILL_SELL;
				end
			end
			default: ;
		endcase
	end

	assign result = res_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("not busy after accepted word");
	a_fill_side: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((result.fill_side == FILL_NONE) == (result.fill_quantity == '0)))
		else $error("fill side disagrees with quantity");
	a_div_once: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> state_q == ST_DIV) else $error("divider started outside walk end");

endmodule

[tb/sv/lobm_checker.sv]
`timescale 1ns / 100ps
// Checker for the order book matcher: watches request and result words, predicts, compares.
module lobm_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  lobm_pkg::lobm_req_t req,
	input  logic                done,
	input  lobm_pkg::lobm_res_t result,
	output int                  errors,
	output int                  pending,
	output int                  orders_seen,
	output int                  fills_seen
);
	import lobm_pkg::*;

	// shadow book
	bit [31:0] rest_qty [MAX_ORDERS];
	bit        id_seen  [MAX_ORDERS];
	bit        id_dead  [MAX_ORDERS];
	bit [9:0]  link     [MAX_ORDERS];
	bit [9:0]  lvl_head [LVL_NUM];
	bit [9:0]  lvl_tail [LVL_NUM];
	bit        lvl_busy [LVL_NUM];

	lobm_res_t fills_due[$];

	assign pending = fills_due.size();

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void pop_level(int lvl);
		if (lvl_head[lvl] == lvl_tail[lvl])
			lvl_busy[lvl] = 0;
		else
			lvl_head[lvl] = link[lvl_head[lvl]];
	endfunction

	function automatic lobm_res_t match_order(lobm_req_t w);
		lobm_res_t       r;
		bit [31:0]       want, filled, m;
		longint unsigned cost, q, rm, avg;
		int              book, p, lvl, h, rlvl;
		bit              is_buy, is_limit;
		r = '0;
		want = w.order_quantity;
		filled = 0;
		cost = 0;
		if (w.req_type == REQ_CANCEL) begin
			if (id_seen[w.order_id] && !id_dead[w.order_id])
				id_dead[w.order_id] = 1;
			return r;
		end
		if (!(w.req_type == REQ_LIMIT || w.req_type == REQ_MARKET) ||
		    !(w.side == SIDE_BUY || w.side == SIDE_SELL))
			return r;
		is_buy = (w.side == SIDE_BUY);
		is_limit = (w.req_type == REQ_LIMIT);
		book = is_buy ? 1 : 0;
		for (int k = 0; k < PRICE_LEVELS && want > 0; k++) begin
			p = is_buy ? k : PRICE_LEVELS - 1 - k;
			if (is_limit && is_buy && p > w.limit_price)
				break;
			if (is_limit && !is_buy && p < w.limit_price)
				break;
			lvl = book * PRICE_LEVELS + p;
			while (lvl_busy[lvl] && want > 0) begin
				h = lvl_head[lvl];
				if (id_dead[h]) begin
					pop_level(lvl);
					continue;
				end
				m = rest_qty[h] < want ? rest_qty[h] : want;
				want -= m;
				filled += m;
				cost += longint'(m) * p;
				rest_qty[h] -= m;
				if (rest_qty[h] == 0) begin
					id_dead[h] = 1;
					pop_level(lvl);
				end
			end
		end
		if (is_limit) begin
			if (want > 0) begin
				if (!id_seen[w.order_id] && !id_dead[w.order_id]) begin
					id_seen[w.order_id] = 1;
					rest_qty[w.order_id] = want;
					rlvl = (1 - book) * PRICE_LEVELS + w.limit_price;
					if (!lvl_busy[rlvl]) begin
						lvl_head[rlvl] = w.order_id;
						lvl_busy[rlvl] = 1;
					end else begin
						link[lvl_tail[rlvl]] = w.order_id;
					end
					lvl_tail[rlvl] = w.order_id;
				end
			end else begin
				id_dead[w.order_id] = 1;
			end
		end
		if (filled > 0) begin
			q = cost / filled;
			rm = cost % filled;
			avg = (q << FRACTION_BITS) + ((rm << FRACTION_BITS) / filled);
			if (avg > {AVG_W{1'b1}})
				avg = {AVG_W{1'b1}};
			r.avg_price = avg[AVG_W-1:0];
			r.fill_quantity = filled;
			r.fill_side = is_buy ? FILL_BUY : FILL_SELL;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lobm_res_t exp_word;
		if (!arst_n) begin
			foreach (id_seen[i]) begin
				id_seen[i] = 0;
				id_dead[i] = 0;
			end
			foreach (lvl_busy[i])
				lvl_busy[i] = 0;
			fills_due.delete();
			errors = 0;
			orders_seen = 0;
			fills_seen = 0;
		end else begin
			if (done) begin
				if (fills_due.size() == 0) begin
					report_mismatch("unexpected result word", result, 0);
				end else begin
					exp_word = fills_due[0];
					fills_due.delete(0);
					if (result.avg_price !== exp_word.avg_price)
						report_mismatch("avg_price", result.avg_price, exp_word.avg_price);
					if (result.fill_quantity !== exp_word.fill_quantity)
						report_mismatch("fill_quantity", result.fill_quantity,
						                exp_word.fill_quantity);
					if (result.fill_side !== exp_word.fill_side)
						report_mismatch("fill_side", result.fill_side, exp_word.fill_side);
					if (exp_word.fill_quantity != 0)
						fills_seen++;
				end
			end
			if (start && !busy) begin
				fills_due.insert(fills_due.size(), match_order(req));
				orders_seen++;
			end
		end
	end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Top of the order book matcher testbench: clock, reset, stimulus and verdict.
module testbench;
	import lobm_pkg::*;

	localparam int  RAND_ORDERS = 600;
	localparam longint CYCLE_LIMIT = 8_000_000;
	localparam int  REQ_BITS = $bits(lobm_req_t);

	logic      clk;
	logic      arst_n;
	logic      start;
	lobm_req_t req;
	logic      busy;
	logic      done;
	lobm_res_t result;
	int        errors, pending, orders_seen, fills_seen;
	longint    cycles;
	int        sender_idle;
	bit [9:0]  fresh_id;
	bit [9:0]  recent_ids[$];

	limit_order_book_matcher_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .result(result)
	);

	lobm_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .errors(errors), .pending(pending),
		.orders_seen(orders_seen), .fills_seen(fills_seen)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[limit_order_book_matcher_unit] ERROR");
			$finish;
		end
	end

	function automatic lobm_req_t mk(logic [1:0] t, logic [1:0] s, int id, int p,
	                                 logic [31:0] q);
		lobm_req_t w;
		w.req_type = t;
		w.side = s;
		w.order_id = id[9:0];
		w.limit_price = p[9:0];
		w.order_quantity = q;
		return w;
	endfunction

	// drive a word at the falling edge, hold it until taken
	task automatic send_word(lobm_req_t w);
		bit taken;
		@(negedge clk);
		start = 1'b1;
		req = w;
		do begin
			@(posedge clk);
			taken = !busy;
		end while (!taken);
		if ($urandom_range(99) < sender_idle) begin
			@(negedge clk);
			start = 1'b0;
			req = lobm_req_t'(REQ_BITS'({$urandom, $urandom}));
			repeat ($urandom_range(6)) @(negedge clk);
		end
	endtask

	function automatic lobm_req_t rand_order(output bit noise);
		lobm_req_t w;
		int        r, id, p;
		logic [1:0] s;
		logic [31:0] q;
		r = $urandom_range(99);
		noise = 0;
		s = $urandom_range(1) ? SIDE_SELL : SIDE_BUY;
		if ($urandom_range(9) == 0 || recent_ids.size() == 0) begin
			id = $urandom_range(1023);
		end else begin
			id = fresh_id;
			fresh_id++;
		end
		p = ($urandom_range(9) == 0) ? $urandom_range(1023) : 480 + $urandom_range(40);
		case ($urandom_range(19))
			0: q = 0;
			1, 2: q = $urandom;
			default: q = $urandom_range(200, 1);
		endcase
		if (r < 4) begin
			noise = 1;
			w = lobm_req_t'(REQ_BITS'({$urandom, $urandom}));
			if ($urandom_range(1))
				w.req_type = REQ_OTHER;
			else
				w.side = $urandom_range(1) ? SIDE_NONE_HI : SIDE_NONE;
		end else if (r < 14) begin
			if (recent_ids.size() > 0 && $urandom_range(3) != 0)
				id = recent_ids[$urandom_range(recent_ids.size() - 1)];
			w = mk(REQ_CANCEL, 2'($urandom_range(3)), id, $urandom_range(1023), $urandom);
		end else if (r < 24) begin
			w = mk(REQ_MARKET, s, id, $urandom_range(1023), q);
		end else begin
			w = mk(REQ_LIMIT, s, id, p, q);
		end
		recent_ids = {recent_ids, w.order_id};
		if (recent_ids.size() > 32)
			recent_ids.delete(0);
		return w;
	endfunction

	initial begin
		lobm_req_t word;
		bit        noise;
		int        sent;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		fresh_id = 0;
		sender_idle = 8;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: crossing, partial and full fills, cancels, reuse, rejects
		send_word(mk(REQ_LIMIT, SIDE_SELL, 900, 510, 10));
		send_word(mk(REQ_LIMIT, SIDE_SELL, 901, 505, 5));
		send_word(mk(REQ_LIMIT, SIDE_SELL, 902, 1023, 32'hFFFF_FFFF));
		send_word(mk(REQ_LIMIT, SIDE_BUY, 903, 0, 7));
		send_word(mk(REQ_LIMIT, SIDE_BUY, 904, 507, 3));
		send_word(mk(REQ_MARKET, SIDE_BUY, 905, 0, 4));
		send_word(mk(REQ_CANCEL, SIDE_BUY, 900, 0, 0));
		send_word(mk(REQ_CANCEL, SIDE_NONE_HI, 900, 1023, 32'hFFFF_FFFF));
		send_word(mk(REQ_CANCEL, SIDE_SELL, 950, 0, 0));
		send_word(mk(REQ_MARKET, SIDE_BUY, 906, 0, 20));
		send_word(mk(REQ_LIMIT, SIDE_SELL, 907, 0, 9));
		send_word(mk(REQ_LIMIT, SIDE_BUY, 908, 0, 2));
		send_word(mk(REQ_LIMIT, SIDE_BUY, 903, 600, 5));
		send_word(mk(REQ_LIMIT, SIDE_BUY, 909, 300, 0));
		send_word(mk(REQ_MARKET, SIDE_SELL, 910, 0, 0));
		send_word(mk(REQ_OTHER, SIDE_NONE_HI, 1023, 1023, 32'hFFFF_FFFF));
		send_word(mk(REQ_LIMIT, SIDE_NONE, 912, 500, 50));
		send_word(mk(REQ_MARKET, SIDE_NONE_HI, 913, 500, 50));
		send_word(mk(REQ_LIMIT, SIDE_BUY, 911, 1023, 1));
		send_word(mk(REQ_LIMIT, SIDE_BUY, 914, 200, 40));
		send_word(mk(REQ_MARKET, SIDE_SELL, 915, 0, 32'hFFFF_FFFF));
		send_word(mk(REQ_MARKET, SIDE_BUY, 916, 1023, 32'hFFFF_FFFF));

		sent = 0;
		while (sent < RAND_ORDERS) begin
			sender_idle = (sent < RAND_ORDERS / 3) ? 8 :
			              (sent < 2 * RAND_ORDERS / 3) ? 78 : 0;
			word = rand_order(noise);
			send_word(word);
			if (!noise)
				sent++;
		end
		@(negedge clk);
		start = 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("covered %0d orders (limit, market, cancel and rejected words),", orders_seen);
		$display("%0d of them filled, with sender gaps at three rates", fills_seen);
		if (errors == 0)
			$display("[limit_order_book_matcher_unit] OK");
		else
			$display("[limit_order_book_matcher_unit] ERROR");
		$finish;
	end

endmodule
